// ===== rtl/ecbd_pkg.sv =====
// Shared types, constants and the segment table of the encoder countdown blinker display.
package ecbd_pkg;

	localparam int CNT_W       = 14;
	localparam int CFG8_W      = 8;
	localparam int BCD_DIGITS  = 5;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_ADDR_W  = 2;

	localparam logic [CNT_W-1:0]  MAX_COUNT_RST = 14'd9999;
	localparam logic [CFG8_W-1:0] HALF_RST      = 8'd100;
	localparam logic [CFG8_W-1:0] LOCKOUT_RST   = 8'd100;
	localparam logic [CFG8_W-1:0] LEDS_ON       = 8'hFF;
	localparam logic [CFG8_W-1:0] LEDS_OFF      = 8'h00;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MAX_COUNT = 2'd0,
		REG_BLINK_HALF = 2'd1,
		REG_LOCKOUT = 2'd2
	} ecbd_reg_t;

	typedef logic [3:0] bcd_digit_t;

	typedef struct packed {
		logic [CNT_W-1:0]  max_count;
		logic [CFG8_W-1:0] blink_half;
		logic [CFG8_W-1:0] lockout;
	} ecbd_cfg_t;

	// Count movements of one tick, in the order they are applied.
	typedef struct packed {
		logic enc_inc;
		logic enc_dec;
		logic blink_dec;
	} ecbd_chg_t;

	// Active-low common-anode pattern of one decimal digit.
	function automatic logic [7:0] seg_code(input bcd_digit_t d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ecbd_core.sv =====
// Encoder counter, button lockout and countdown blinker state.
module ecbd_core import ecbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             enc_clk,
	input  logic             enc_data,
	input  logic             button_level,
	input  ecbd_cfg_t        cfg,
	output ecbd_chg_t        chg,
	output logic [CNT_W-1:0] count_nxt,
	output logic             leds_nxt,
	output logic             blink_nxt
);

	logic              last_clk_q, armed_q, blink_q, leds_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CFG8_W-1:0] tick_q, lock_q;

	logic              armed_n, b1;
	logic [CNT_W-1:0]  c1;
	logic [CFG8_W-1:0] t1, t2, lock_n;

	// Next state for one tick: encoder, then button, then blinker.
	always_comb begin
		chg = '0;
		c1 = cnt_q;
		if (enc_clk != last_clk_q) begin
			if (enc_data == enc_clk) begin
				if (cnt_q != '0) begin
					chg.enc_dec = 1'b1;
					c1 = cnt_q - 1'b1;
				end
			end else if (cnt_q < cfg.max_count) begin
				chg.enc_inc = 1'b1;
				c1 = cnt_q + 1'b1;
			end
		end

		lock_n = lock_q;
		armed_n = armed_q;
		b1 = blink_q;
		t1 = tick_q;
		if (lock_q != '0) begin
			lock_n = lock_q - 1'b1;
		end else if (button_level) begin
			armed_n = 1'b1;
		end else if (armed_q) begin
			armed_n = 1'b0;
			b1 = 1'b1;
			t1 = '0;
			lock_n = cfg.lockout;
		end

		count_nxt = c1;
		leds_nxt = leds_q;
		blink_nxt = b1;
		t2 = t1;
		if (b1) begin
			if (c1 == '0) begin
				blink_nxt = 1'b0;
				leds_nxt = 1'b0;
			end else if (t1 == cfg.blink_half) begin
				t2 = '0;
				leds_nxt = !leds_q;
				// Going dark takes one off the count.
				if (leds_q) begin
					chg.blink_dec = 1'b1;
					count_nxt = c1 - 1'b1;
					if (c1 == CNT_W'(1))
						blink_nxt = 1'b0;
				end
			end
		end
	end

	// State registers advance once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_clk_q <= 1'b1;
			armed_q <= 1'b1;
			cnt_q <= '0;
			tick_q <= '0;
			blink_q <= 1'b0;
			leds_q <= 1'b0;
			lock_q <= '0;
		end else if (step) begin
			last_clk_q <= enc_clk;
			armed_q <= armed_n;
			cnt_q <= count_nxt;
			tick_q <= t2 + 1'b1;
			blink_q <= blink_nxt;
			leds_q <= leds_nxt;
			lock_q <= lock_n;
		end
	end

	// Blinking never runs on a zero count.
	a_blink_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q |-> cnt_q != '0)
		else $error("blinking with zero count");

	// The LEDs are lit only while blinking.
	a_leds_blink: assert property (@(posedge clk) disable iff (!arst_n)
		leds_q |-> blink_q)
		else $error("LEDs lit outside blinking");

	// A count movement from the encoder is a single direction.
	a_enc_dir: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(chg.enc_inc && chg.enc_dec))
		else $error("encoder moved both ways");

endmodule

// ===== rtl/ecbd_disp.sv =====
// Decimal shadow of the count and the multiplexed seven-segment scan.
module ecbd_disp import ecbd_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  ecbd_chg_t  chg,
	output logic [3:0] digit_enable,
	output logic [7:0] segment_pattern
);

	localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DIGIT_COUNT - 1);

	bcd_digit_t [BCD_DIGITS-1:0] bcd_q, bcd1, bcd2;
	logic [SCAN_W-1:0]           scan_q;
	bcd_digit_t                  shown;

	// Add one with decimal carry.
	function automatic bcd_digit_t [BCD_DIGITS-1:0] bcd_inc(
		input bcd_digit_t [BCD_DIGITS-1:0] v);
		bcd_digit_t [BCD_DIGITS-1:0] r;
		logic cy;
		r = v;
		cy = 1'b1;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (cy) begin
				if (v[i] == 4'd9) begin
					r[i] = 4'd0;
				end else begin
					r[i] = v[i] + 1'b1;
					cy = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Subtract one with decimal borrow; never called on zero.
	function automatic bcd_digit_t [BCD_DIGITS-1:0] bcd_dec(
		input bcd_digit_t [BCD_DIGITS-1:0] v);
		bcd_digit_t [BCD_DIGITS-1:0] r;
		logic bw;
		r = v;
		bw = 1'b1;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bw) begin
				if (v[i] == 4'd0) begin
					r[i] = 4'd9;
				end else begin
					r[i] = v[i] - 1'b1;
					bw = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Follow the binary count and pick the scanned digit.
	always_comb begin
		if (chg.enc_inc)
			bcd1 = bcd_inc(bcd_q);
		else if (chg.enc_dec)
			bcd1 = bcd_dec(bcd_q);
		else
			bcd1 = bcd_q;
		bcd2 = chg.blink_dec ? bcd_dec(bcd1) : bcd1;

		shown = 4'd0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (int'(scan_q) == i)
				shown = bcd2[i];
		end
		for (int i = 0; i < 4; i++)
			digit_enable[i] = (int'(scan_q) == i);
		segment_pattern = seg_code(shown);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
			scan_q <= '0;
		end else if (step) begin
			bcd_q <= bcd2;
			scan_q <= (scan_q == SCAN_LAST) ? '0 : scan_q + 1'b1;
		end
	end

	// Every stored digit is a decimal digit.
	a_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_q[0] <= 4'd9 && bcd_q[1] <= 4'd9 && bcd_q[2] <= 4'd9 &&
		bcd_q[3] <= 4'd9 && bcd_q[4] <= 4'd9)
		else $error("decimal shadow digit out of range");

	// The scan position stays on a fitted digit.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(scan_q) < DIGIT_COUNT)
		else $error("scan position beyond last digit");

	// At most one digit is driven at a time.
	a_digit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(digit_enable))
		else $error("more than one digit enabled");

endmodule

// ===== rtl/encoder_countdown_blinker_display.sv =====
// Top level of the encoder countdown blinker display: input and result registers.
//
//  channel | direction | tdata bits (low first)
//  s_*     | in        | enc_clk[0], enc_data[1], button_level[2], zero[7:3]
//  m_*     | out       | digit_enable[3:0], segment_pattern[11:4], led_bank[19:12],
//          |           | count_value[33:20], blink_active[34], zero[39:35]
//  cfg_*   | in        | index 0 max_count, 1 blink_half_period, 2 button_lockout
//
// One tick request per cycle is accepted while the result side is not stalled; each result passes
// through the input register, the state update and the result register, in that order.
// Reset clears all state but the data registers and loads the defaults; no clearing pass is needed.
// A stalled result holds the result register; the input register keeps accepting until full.
module encoder_countdown_blinker_display import ecbd_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,    // enc_clk, enc_data, button_level
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,    // digit_enable, segment_pattern, led_bank,
	                                           // count_value, blink_active
	input  logic                   cfg_wen,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CNT_W-1:0]       cfg_wdata
);

	logic                   vld_s1, vld_s2;
	logic [2:0]             item_s1;
	logic [OUT_TDATA_W-1:0] tdata_s2;
	logic                   advance;
	ecbd_cfg_t              cfg_q;
	ecbd_chg_t              chg;
	logic [CNT_W-1:0]       count_nxt;
	logic                   leds_nxt, blink_nxt;
	logic [3:0]             digit_enable;
	logic [7:0]             segment_pattern;

	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign m_tvalid = vld_s2;
	assign m_tdata  = tdata_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_count <= MAX_COUNT_RST;
			cfg_q.blink_half <= HALF_RST;
			cfg_q.lockout <= LOCKOUT_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_MAX_COUNT: cfg_q.max_count <= cfg_wdata;
				REG_BLINK_HALF: cfg_q.blink_half <= cfg_wdata[CFG8_W-1:0];
				REG_LOCKOUT: cfg_q.lockout <= cfg_wdata[CFG8_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (s_tready)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= s_tdata[2:0];
	end

	ecbd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.enc_clk      (item_s1[0]),
		.enc_data     (item_s1[1]),
		.button_level (item_s1[2]),
		.cfg          (cfg_q),
		.chg          (chg),
		.count_nxt    (count_nxt),
		.leds_nxt     (leds_nxt),
		.blink_nxt    (blink_nxt)
	);

	ecbd_disp #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_disp (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.chg             (chg),
		.digit_enable    (digit_enable),
		.segment_pattern (segment_pattern)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (advance)
			vld_s2 <= 1'b1;
		else if (m_tready)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			tdata_s2 <= {5'b0, blink_nxt, count_nxt, leds_nxt ? LEDS_ON : LEDS_OFF,
				segment_pattern, digit_enable};
	end

endmodule

// ===== sim/ecbd_tick_checker.sv =====
// Checker for the encoder countdown blinker display: predicts each tick result and compares it.
`timescale 1ns / 100ps

module ecbd_tick_checker import ecbd_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,    // enc_clk, enc_data, button_level
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,    // digit_enable, segment_pattern, led_bank,
	                                           // count_value, blink_active
	input  logic                   cfg_wen,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CNT_W-1:0]       cfg_wdata,
	output int                     error_count,
	output int                     pending,
	output int                     compared
);

	// Common-anode patterns, digit 0 in the lowest byte.
	localparam logic [8*10-1:0] SEG_TABLE = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic [3:0]       digit_enable;
		logic [7:0]       segment_pattern;
		logic [7:0]       led_bank;
		logic [CNT_W-1:0] count_value;
		logic             blink_active;
	} tick_result_t;

	tick_result_t expected_ticks[$];

	// Configuration copy.
	logic [CNT_W-1:0]  max_count_q;
	logic [CFG8_W-1:0] half_period_q;
	logic [CFG8_W-1:0] lockout_cfg_q;

	// Predicted block state.
	logic              enc_last_q;
	logic              armed_q;
	logic [CNT_W-1:0]  count_q;
	logic [7:0]        ticks_q;
	logic              blinking_q;
	logic              lit_q;
	int                scan_q;
	logic [7:0]        lockout_left_q;

	// Advance the predicted state by one tick and return what the display shows.
	task automatic predict_tick(input logic [2:0] pins, output tick_result_t r);
		logic pin_clk;
		logic pin_data;
		logic pin_btn;
		int   scale;
		int   shown;
		int   k;
		pin_clk  = pins[0];
		pin_data = pins[1];
		pin_btn  = pins[2];

		// A change of the encoder clock is one detent step.
		if (pin_clk != enc_last_q) begin
			enc_last_q = pin_clk;
			if (pin_data == pin_clk) begin
				if (count_q != '0)
					count_q = count_q - 1'b1;
			end else if (count_q < max_count_q) begin
				count_q = count_q + 1'b1;
			end
		end

		// The button is ignored while the lockout runs.
		if (lockout_left_q != 8'd0) begin
			lockout_left_q = lockout_left_q - 8'd1;
		end else begin
			if (pin_btn)
				armed_q = 1'b1;
			if (armed_q && !pin_btn) begin
				armed_q        = 1'b0;
				blinking_q     = 1'b1;
				ticks_q        = 8'd0;
				lockout_left_q = lockout_cfg_q;
			end
		end

		// Countdown blinking; the count drops each time the LEDs go dark.
		if (blinking_q) begin
			if (count_q == '0) begin
				blinking_q = 1'b0;
				lit_q      = 1'b0;
			end else if (ticks_q == half_period_q) begin
				ticks_q = 8'd0;
				lit_q   = ~lit_q;
				if (!lit_q) begin
					count_q = count_q - 1'b1;
					if (count_q == '0)
						blinking_q = 1'b0;
				end
			end
		end

		// One decimal digit per tick on the multiplexed display.
		scale = 1;
		for (k = 0; k < scan_q; k++)
			scale = scale * 10;
		shown = (int'(count_q) / scale) % 10;
		r.digit_enable    = (scan_q < 4) ? 4'(1 << scan_q) : 4'd0;
		r.segment_pattern = SEG_TABLE[shown*8 +: 8];
		r.led_bank        = lit_q ? LEDS_ON : LEDS_OFF;
		r.count_value     = count_q;
		r.blink_active    = blinking_q;

		scan_q  = (scan_q + 1 >= DIGIT_COUNT) ? 0 : scan_q + 1;
		ticks_q = ticks_q + 8'd1;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Watch the configuration port and both channels on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		tick_result_t fresh;
		if (!arst_n) begin
			max_count_q    = MAX_COUNT_RST;
			half_period_q  = HALF_RST;
			lockout_cfg_q  = LOCKOUT_RST;
			enc_last_q     = 1'b1;
			armed_q        = 1'b1;
			count_q        = '0;
			ticks_q        = 8'd0;
			blinking_q     = 1'b0;
			lit_q          = 1'b0;
			scan_q         = 0;
			lockout_left_q = 8'd0;
			expected_ticks.delete();
			error_count    = 0;
			pending        = 0;
			compared       = 0;
		end else begin
			if (cfg_wen) begin
				case (ecbd_reg_t'(cfg_addr))
					REG_MAX_COUNT:  max_count_q   = cfg_wdata;
					REG_BLINK_HALF: half_period_q = cfg_wdata[CFG8_W-1:0];
					REG_LOCKOUT:    lockout_cfg_q = cfg_wdata[CFG8_W-1:0];
					default: ;
				endcase
			end

			// Compare a result with the oldest outstanding prediction.
			if (m_tvalid && m_tready) begin
				if (expected_ticks.size() == 0) begin
					error_count++;
					$display("%0t: result %h arrived with no tick request outstanding",
						$time, m_tdata);
				end else begin
					want = expected_ticks.pop_front();
					compared++;
					check_field("digit_enable", want.digit_enable, m_tdata[3:0]);
					check_field("segment_pattern", want.segment_pattern, m_tdata[11:4]);
					check_field("led_bank", want.led_bank, m_tdata[19:12]);
					check_field("count_value", want.count_value, m_tdata[33:20]);
					check_field("blink_active", want.blink_active, m_tdata[34]);
				end
			end

			// Each accepted tick request yields exactly one result.
			if (s_tvalid && s_tready) begin
				predict_tick(s_tdata[2:0], fresh);
				expected_ticks.push_back(fresh);
			end
			pending = expected_ticks.size();
		end
	end

endmodule

// ===== sim/encoder_countdown_blinker_display_test.sv =====
// Testbench top of the encoder countdown blinker display: stimulus, idling and verdict.
`timescale 1ns / 100ps

module encoder_countdown_blinker_display_test;
	import ecbd_pkg::*;

	localparam int DIGIT_COUNT    = 4;
	localparam int PHASE_TICKS    = 240;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 200;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // enc_clk, enc_data, button_level
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;    // digit_enable, segment_pattern, led_bank,
	                                    // count_value, blink_active
	logic                   cfg_wen;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CNT_W-1:0]       cfg_wdata;

	int error_count;
	int pending;
	int compared;

	int  ticks_sent;
	int  settings_used;
	int  quiet_cycles;
	int  stall_left;
	bit  sender_gaps;
	bit  tail_quiet;

	// Random encoder and button model.
	logic enc_level;
	logic enc_up;
	logic btn_level;
	int   btn_run;

	encoder_countdown_blinker_display #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	ecbd_tick_checker #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.error_count(error_count),
		.pending(pending),
		.compared(compared)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random stall bursts, none in the closing phase.
	always @(negedge clk) begin
		if (tail_quiet || !arst_n) begin
			m_tready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles with no accepted request, result or register write.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("encoder_countdown_blinker_display_test: errors");
				$finish;
			end
		end
	end

	// Offer one tick request, with an occasional gap before it while sender gaps are enabled.
	task automatic send_tick(input logic pin_clk, input logic pin_data, input logic pin_btn);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, pin_btn, pin_data, pin_clk};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		ticks_sent++;
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input ecbd_reg_t idx, input logic [CNT_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic load_settings(input int max_count, input int half, input int lockout);
		settle_block();
		write_reg(REG_MAX_COUNT, CNT_W'(max_count));
		write_reg(REG_BLINK_HALF, CNT_W'(half));
		write_reg(REG_LOCKOUT, CNT_W'(lockout));
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	// Encoder steps in runs of one direction, button held and released in runs, some random pins.
	task automatic random_tick();
		logic data;
		if ($urandom_range(0, 19) == 0)
			enc_up = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 2) == 0)
			enc_level = ~enc_level;
		data = enc_up ? ~enc_level : enc_level;
		if (btn_run == 0) begin
			btn_level = ~btn_level;
			btn_run   = btn_level ? $urandom_range(2, 40) : $urandom_range(1, 8);
		end else begin
			btn_run--;
		end
		if ($urandom_range(0, 11) == 0) begin
			enc_level = 1'($urandom_range(0, 1));
			send_tick(enc_level, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			send_tick(enc_level, data, btn_level);
		end
	endtask

	task automatic run_phase(input int max_count, input int half, input int lockout,
		input bit hold_midway);
		int n;
		load_settings(max_count, half, lockout);
		for (n = 0; n < PHASE_TICKS; n++) begin
			if (hold_midway && n == PHASE_TICKS / 2)
				settle_block();
			random_tick();
		end
	endtask

	initial begin
		int p;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_wen       = 1'b0;
		cfg_addr      = REG_MAX_COUNT;
		cfg_wdata     = '0;
		ticks_sent    = 0;
		settings_used = 1;
		quiet_cycles  = 0;
		stall_left    = 0;
		sender_gaps   = 1'b1;
		tail_quiet    = 1'b0;
		enc_level     = 1'b1;
		enc_up        = 1'b1;
		btn_level     = 1'b1;
		btn_run       = 10;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: steps both ways and the floor at zero.
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);

		// Small limit: press at zero stops at once, the ceiling, then a full countdown.
		load_settings(3, 1, 0);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		repeat (8) send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);

		// Limit lowered under the count: no step up, a step down still acts.
		settle_block();
		write_reg(REG_MAX_COUNT, CNT_W'(1));
		cfg_wen <= 1'b0;
		settings_used++;
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);

		// Random phases over extreme and small settings, half period zero among them.
		run_phase(9999, 255, 255, 1'b0);
		run_phase(0, 1, 0, 1'b0);
		run_phase(12, 0, 5, 1'b0);
		for (p = 0; p < 4; p++)
			run_phase($urandom_range(1, 40), $urandom_range(1, 6), $urandom_range(0, 12),
				p == 0);
		sender_gaps = 1'b0;
		tail_quiet  = 1'b1;
		run_phase(25, 2, 3, 1'b0);

		settle_block();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d tick requests under %0d register settings, %0d results compared.",
			ticks_sent, settings_used, compared);
		$display("Covered encoder steps both ways with clamping, locked-out presses and blinking.");
		if (error_count == 0 && pending == 0) begin
			$display("encoder_countdown_blinker_display_test: clean");
		end else begin
			$display("encoder_countdown_blinker_display_test: errors");
		end
		$finish;
	end

endmodule
